FILE: rtl/ilid_pkg.sv
// ilid_pkg: shared types and constants of the indexed list block.
// No dependencies; imported by the top level.
package ilid_pkg;

   localparam int CMD_W  = 3;
   localparam int POS_W  = 16;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_FRONT  = 3'd1,
      CMD_APPEND = 3'd2,
      CMD_BEFORE = 3'd3,
      CMD_DELETE = 3'd4
   } cmd_type;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   localparam logic [VAL_W-1:0] NO_VALUE = '1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SHIFT,
      S_FIN
   } state_type;

endpackage

FILE: rtl/ilid_ram.sv
// ilid_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ilid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/indexed_list_insert_delete.sv
// indexed_list_insert_delete: ordered list of signed words kept in one RAM.
// Depends on ilid_pkg and ilid_ram.
//
// Holds up to CAPACITY signed 32-bit values in order plus the current length.
// A command beat (start high while busy is low) reads, inserts or deletes at a
// position. Every beat yields exactly one response beat, shown for one cycle
// with rsp_valid high; there is no back-pressure on the response side.
// Flow: commands answered without touching the list (out of range, full,
// unused codes) respond in the next cycle and leave busy low, so another
// command may follow at once. A read in range passes through S_READ, which
// takes the registered RAM output into the response. An insert or delete
// moves every later entry by one slot through the single RAM read and write
// port, one entry per cycle, then S_FIN writes the new value (insert only)
// and updates the length; the response shows in the same cycle busy drops.
// The RAM needs no clearing pass; entries at or above the length are never read.
module indexed_list_insert_delete
   import ilid_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_item_value,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]       rsp_status,
   output logic [LEN_W-1:0]        rsp_length
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   // latched command
   cmd_type           cmd_ff, cmd_in;
   logic [AW-1:0]     pos_ff, pos_in;        // insert target / delete slot
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [AW-1:0]     cursor_ff, cursor_in;  // next slot to write while moving

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [CW-1:0]     rsp_count;
   logic [CW+LEN_W-1:0] rsp_count_wide;

   // RAM port
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [AW-1:0]     rd_addr;
   logic [VAL_W-1:0]  rd_data;

   logic              accept;
   logic              full;
   logic [POS_W-1:0]  count_pos;
   logic [AW-1:0]     target;
   cmd_type           req_cmd_e;

   ilid_ram #(
      .WIDTH(VAL_W),
      .DEPTH(CAPACITY)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign full      = (count_ff == CW'(CAPACITY));
   assign count_pos = POS_W'(count_ff);
   assign req_cmd_e = cmd_type'(req_cmd);

   // length field carries the low bits of the count
   assign rsp_count_wide = (CW + LEN_W)'(rsp_count);
   assign rsp_length_in  = rsp_count_wide[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cursor_ff     <= cursor_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cursor_in     = cursor_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count     = count_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = val_ff;
      rd_addr       = '0;
      target        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in        = req_cmd_e;
               val_in        = req_item_value;
               // default: answer right away, list untouched
               rsp_valid_in  = 1'b1;
               rsp_value_in  = NO_VALUE;
               rsp_status_in = STAT_DONE;
               case (req_cmd_e)
                  CMD_READ: begin
                     if (req_position < count_pos) begin
                        rd_addr      = AW'(req_position);
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end else begin
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  CMD_FRONT, CMD_APPEND, CMD_BEFORE: begin
                     if (req_cmd_e == CMD_BEFORE && req_position > count_pos) begin
                        rsp_status_in = STAT_RANGE;
                     end else if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        case (req_cmd_e)
                           CMD_FRONT:  target = '0;
                           CMD_APPEND: target = AW'(count_ff);
                           default:    target = AW'(req_position);
                        endcase
                        pos_in       = target;
                        rsp_valid_in = 1'b0;
                        if (count_ff > CW'(target)) begin
                           // move entries up, starting from the tail
                           rd_addr   = AW'(count_ff - CW'(1));
                           cursor_in = AW'(count_ff);
                           state_in  = S_SHIFT;
                        end else begin
                           state_in = S_FIN;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (req_position < count_pos) begin
                        pos_in       = AW'(req_position);
                        cursor_in    = AW'(req_position);
                        rsp_valid_in = 1'b0;
                        if (CW'(req_position) + CW'(1) < count_ff) begin
                           // move entries down, starting just above the hole
                           rd_addr  = AW'(CW'(req_position) + CW'(1));
                           state_in = S_SHIFT;
                        end else begin
                           state_in = S_FIN;
                        end
                     end else begin
                        rsp_status_in = STAT_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = rd_data;
            rsp_status_in = STAT_DONE;
            state_in      = S_IDLE;
         end

         S_SHIFT: begin
            // rd_data holds the neighbor read in the previous cycle
            wr_en   = 1'b1;
            wr_addr = cursor_ff;
            wr_data = rd_data;
            if (cmd_ff == CMD_DELETE) begin
               if (CW'(cursor_ff) + CW'(2) < count_ff) begin
                  rd_addr   = AW'(CW'(cursor_ff) + CW'(2));
                  cursor_in = cursor_ff + AW'(1);
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               if (cursor_ff - AW'(1) > pos_ff) begin
                  rd_addr   = cursor_ff - AW'(2);
                  cursor_in = cursor_ff - AW'(1);
               end else begin
                  state_in = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (cmd_ff == CMD_DELETE) begin
               count_in = count_ff - CW'(1);
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = val_ff;
               count_in = count_ff + CW'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_value_in  = NO_VALUE;
            rsp_status_in = STAT_DONE;
            rsp_count     = count_in;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

   // every accepted beat either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (accept && !reset) |=> (rsp_valid || busy))
      else $error("accepted command neither answered nor in progress");

   // the finishing cycle always produces a response
   a_fin_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !reset) |=> rsp_valid)
      else $error("no response after finishing cycle");

   // the length only moves in the finishing cycle
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FIN && !reset) |=> $stable(count_ff))
      else $error("length changed outside finishing cycle");

   // while moving with more to read, the read never targets the slot being written
   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && state_in == S_SHIFT) |-> (rd_addr != wr_addr))
      else $error("read and write collide while moving entries");

   // the length never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && cmd_ff != CMD_DELETE) |-> (count_ff < CW'(CAPACITY)))
      else $error("insert finishing on a full list");

endmodule

FILE: tb/tb_indexed_list_insert_delete.sv
// tb_indexed_list_insert_delete: self-checking bench for the indexed list block.
// Depends on ilid_pkg and the indexed_list_insert_delete RTL; a queue-based
// list predicts every response beat, which is checked as it leaves the block.
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete;
   import ilid_pkg::*;

   localparam int CAPACITY = 64;

   // The block gives no names to the spare command codes, so name them here.
   localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   // Traffic mix of the random part: which way the list length drifts.
   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_EVEN
   } mix_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [STAT_W-1:0]       status;
      logic [LEN_W-1:0]        length;
   } rsp_beat_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [CMD_W-1:0]        req_cmd = '0;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_item_value = '0;
   logic                    rsp_valid;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [STAT_W-1:0]       rsp_status;
   logic [LEN_W-1:0]        rsp_length;

   // Predicted list contents, oldest-first queue of predicted response beats.
   logic signed [VAL_W-1:0] list_model[$];
   rsp_beat_type            pending_rsp[$];
   int                      mismatch_count = 0;
   bit                      no_idle = 1'b0;

   indexed_list_insert_delete #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_position  (req_position),
      .req_item_value(req_item_value),
      .rsp_valid     (rsp_valid),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_length    (rsp_length)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction: apply one command to the model list, return its response.
   // Position checks come before the full check on insert-before; spare
   // codes leave the list alone and report done with no value.
   // ---------------------------------------------------------------------
   function automatic rsp_beat_type apply_list_command(input logic [CMD_W-1:0] cmd,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic signed [VAL_W-1:0] val);
      rsp_beat_type r;
      int unsigned  len;
      len = list_model.size();
      r.read_value = NO_VALUE;
      r.status = STAT_DONE;
      case (cmd)
         CMD_READ: begin
            if (pos < len) r.read_value = list_model[pos];
            else r.status = STAT_RANGE;
         end
         CMD_FRONT: begin
            if (len >= CAPACITY) r.status = STAT_FULL;
            else list_model.push_front(val);
         end
         CMD_APPEND: begin
            if (len >= CAPACITY) r.status = STAT_FULL;
            else list_model.push_back(val);
         end
         CMD_BEFORE: begin
            if (pos > len) r.status = STAT_RANGE;
            else if (len >= CAPACITY) r.status = STAT_FULL;
            else list_model.insert(pos, val);
         end
         CMD_DELETE: begin
            if (pos < len) list_model.delete(pos);
            else r.status = STAT_RANGE;
         end
         default: ;
      endcase
      r.length = LEN_W'(list_model.size());
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Mostly back-to-back or short gaps, now and then a long one; the gap
   // lands anywhere inside a multi-cycle shift since busy time varies.
   task automatic idle_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // One command beat: hold start until an edge sees busy low, predict, gap.
   // Only a nonzero gap drops start, so a back-to-back beat keeps it high.
   task automatic send_command(input logic [CMD_W-1:0] cmd,
                               input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
      start <= 1'b1;
      req_cmd <= cmd;
      req_position <= pos;
      req_item_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(apply_list_command(cmd, pos, val));
      idle_gap();
   endtask

   // Hold off new beats until every predicted response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] random_value();
      case ($urandom_range(0, 19))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // Positions mostly inside or just past the list, some anywhere in 16 bits.
   function automatic logic [POS_W-1:0] random_position();
      int unsigned len;
      int          r;
      len = list_model.size();
      r = $urandom_range(0, 99);
      if (r < 70) return POS_W'($urandom_range(0, len));
      if (r < 80) return POS_W'(len + 1);
      if (r < 90) return POS_W'($urandom_range(0, CAPACITY + 2));
      return POS_W'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty list: every position is out of range, spare codes do nothing.
   task automatic test_empty_list();
      send_command(CMD_READ, 16'd0, 32'sd5);
      send_command(CMD_READ, 16'hFFFF, 32'sd0);
      send_command(CMD_DELETE, 16'd0, 32'sd0);
      send_command(CMD_BEFORE, 16'd1, 32'sd9);
      send_command(CMD_SPARE5, 16'd0, 32'sd1);
      send_command(CMD_SPARE6, 16'hFFFF, -32'sd1);
      send_command(CMD_SPARE7, 16'h5555, 32'sh5555_AAAA);
      drain_responses();
   endtask

   // Value extremes through every insert flavor, then reads and deletes at
   // the ends and past the end.
   task automatic test_edges();
      send_command(CMD_BEFORE, 16'd0, 32'sd7);           // insert at length appends
      send_command(CMD_FRONT, 16'hFFFF, 32'sh8000_0000);
      send_command(CMD_APPEND, 16'd0, 32'sh7FFF_FFFF);
      send_command(CMD_APPEND, 16'd0, -32'sd1);
      send_command(CMD_BEFORE, 16'd2, 32'sd0);
      send_command(CMD_BEFORE, 16'd5, 32'sh0F0F_0F0F);   // at length
      send_command(CMD_BEFORE, 16'd7, 32'sd3);           // beyond length
      send_command(CMD_BEFORE, 16'hFFFF, 32'sd3);
      send_command(CMD_READ, 16'd0, 32'sd0);
      send_command(CMD_READ, 16'd5, 32'sd0);
      send_command(CMD_READ, 16'd6, 32'sd0);
      send_command(CMD_DELETE, 16'hFFFF, 32'sd0);
      send_command(CMD_DELETE, 16'd5, 32'sd0);           // last entry
      send_command(CMD_DELETE, 16'd0, 32'sd0);           // first entry
      send_command(CMD_READ, 16'd0, 32'sd0);
      send_command(CMD_READ, 16'd3, 32'sd0);
      drain_responses();
   endtask

   // Fill to capacity, then every insert is refused while full; the position
   // check on insert-before wins over the full check.
   task automatic test_full_list();
      while (list_model.size() < CAPACITY) send_command(CMD_APPEND, 16'd0, random_value());
      send_command(CMD_FRONT, 16'd0, 32'sd1);
      send_command(CMD_APPEND, 16'd0, 32'sd1);
      send_command(CMD_BEFORE, 16'd10, 32'sd1);
      send_command(CMD_BEFORE, POS_W'(CAPACITY), 32'sd1);
      send_command(CMD_BEFORE, POS_W'(CAPACITY + 1), 32'sd1);
      send_command(CMD_READ, POS_W'(CAPACITY - 1), 32'sd0);
      send_command(CMD_READ, POS_W'(CAPACITY), 32'sd0);
      send_command(CMD_DELETE, POS_W'(CAPACITY - 1), 32'sd0);
      send_command(CMD_FRONT, 16'd0, 32'sh1234_5678);    // full again
      send_command(CMD_APPEND, 16'd0, 32'sd2);
      send_command(CMD_DELETE, 16'd0, 32'sd0);
      send_command(CMD_BEFORE, 16'd0, 32'sh7FFF_FFFF);
      send_command(CMD_READ, 16'd0, 32'sd0);
      drain_responses();
   endtask

   // Well-formed traffic with random content; the mix drifts so the length
   // sweeps between empty and full, and idling switches on and off.
   task automatic test_random_traffic(input int count);
      mix_type     mix;
      int          r;
      int unsigned grow_pct;
      logic [CMD_W-1:0] cmd;
      mix = MIX_EVEN;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            mix = mix_type'($urandom_range(0, 2));
            no_idle = ($urandom_range(0, 3) == 0);
         end
         case (mix)
            MIX_GROW:   grow_pct = 70;
            MIX_SHRINK: grow_pct = 20;
            default:    grow_pct = 45;
         endcase
         r = $urandom_range(0, 99);
         if (r < grow_pct) begin
            case ($urandom_range(0, 2))
               0: cmd = CMD_FRONT;
               1: cmd = CMD_APPEND;
               default: cmd = CMD_BEFORE;
            endcase
         end else if (r < grow_pct + (100 - grow_pct) / 2) begin
            cmd = CMD_DELETE;
         end else begin
            cmd = CMD_READ;
         end
         send_command(cmd, random_position(), random_value());
      end
      no_idle = 1'b0;
      drain_responses();
   endtask

   // Noise: any code, any position, any value.
   task automatic test_noise(input int count);
      for (int i = 0; i < count; i++)
         send_command(CMD_W'($urandom_range(0, 7)), POS_W'($urandom), $urandom);
      drain_responses();
   endtask

   // ---------------------------------------------------------------------
   // Response checker: every strobed beat against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type exp_rsp;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t ERROR: unexpected response beat: value %0d status %0d length %0d",
                     $time, rsp_read_value, rsp_status, rsp_length);
            mismatch_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_read_value !== exp_rsp.read_value) begin
               $display("%0t ERROR: rsp_read_value expected %0d actual %0d",
                        $time, exp_rsp.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t ERROR: rsp_status expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_length !== exp_rsp.length) begin
               $display("%0t ERROR: rsp_length expected %0d actual %0d",
                        $time, exp_rsp.length, rsp_length);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_edges();
      test_full_list();
      test_random_traffic(850);
      test_noise(100);

      // Nothing left in flight; give a late or stray beat time to show up.
      drain_responses();
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatch_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
